// ===== src/riqr_pkg.sv =====
// riqr_pkg: shared types and constants for the relative iqr tolerance check
// holds the word structs, the chain control struct and the sequencer states
// no dependencies
package riqr_pkg;

	// store depth and field widths
	localparam int MAX_ITEMS = 1024;
	localparam int LEN_W     = 24;
	localparam int TOL_W     = 16;
	localparam int FRAC_W    = 8;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int PROD_W    = LEN_W + TOL_W;

	// tolerance after reset, 0.25 in 8.8
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd64;

	// input word
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             last;
	} in_word_t;

	// result word
	typedef struct packed {
		logic             within_res;
		logic [LEN_W-1:0] lower_quartile;
		logic [LEN_W-1:0] middle_value;
		logic [LEN_W-1:0] upper_quartile;
		logic             overflow;
	} out_word_t;

	// control for every cell of the sorting chain
	typedef struct packed {
		logic ins;    // insert the broadcast length in order
		logic shift;  // move every entry one cell toward the head
		logic clr;    // drop all entries
	} chain_ctl_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage

// ===== src/riqr_cell.sv =====
// riqr_cell: one cell of the insertion sorting chain, holds one length
// takes its left neighbor's entry or the new length on insert and from its right neighbor on shift
// depends on riqr_pkg
module riqr_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  riqr_pkg::chain_ctl_t      ctl,
	input  logic [riqr_pkg::LEN_W-1:0] new_len,
	input  logic                      left_gt,
	input  logic [riqr_pkg::LEN_W-1:0] left_val,
	input  logic                      left_vld,
	input  logic [riqr_pkg::LEN_W-1:0] right_val,
	input  logic                      right_vld,
	output logic [riqr_pkg::LEN_W-1:0] val,
	output logic                      vld,
	output logic                      gt
);

	logic [riqr_pkg::LEN_W-1:0] val_q;
	logic                       vld_q;
	logic                       take;

	// empty cells count as larger than anything
	assign gt   = !vld_q || (val_q > new_len);
	assign take = ctl.ins && gt;
	assign val  = val_q;
	assign vld  = vld_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= right_vld;
		end else if (take) begin
			vld_q <= left_gt ? left_vld : 1'b1;
		end
	end

	// stored length
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= right_val;
		end else if (take) begin
			val_q <= left_gt ? left_val : new_len;
		end
	end

endmodule

// ===== src/riqr_chain.sv =====
// riqr_chain: row of riqr_cell instances kept in ascending order
// cell 0 is the head; the readout shifts entries toward it
// depends on riqr_pkg and riqr_cell
module riqr_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  riqr_pkg::chain_ctl_t       ctl,
	input  logic [riqr_pkg::LEN_W-1:0] new_len,
	output logic [riqr_pkg::LEN_W-1:0] head_val
);

	logic [riqr_pkg::LEN_W-1:0] val_w [riqr_pkg::MAX_ITEMS];
	logic                       vld_w [riqr_pkg::MAX_ITEMS];
	logic                       gt_w  [riqr_pkg::MAX_ITEMS];

	assign head_val = val_w[0];

	// neighbor wiring, ends tied off as empty
	for (genvar i = 0; i < riqr_pkg::MAX_ITEMS; i++) begin : g_cell
		logic                       l_gt;
		logic [riqr_pkg::LEN_W-1:0] l_val;
		logic                       l_vld;
		logic [riqr_pkg::LEN_W-1:0] r_val;
		logic                       r_vld;

		if (i == 0) begin : g_head
			assign l_gt  = 1'b0;
			assign l_val = '0;
			assign l_vld = 1'b0;
		end else begin : g_mid
			assign l_gt  = gt_w[i-1];
			assign l_val = val_w[i-1];
			assign l_vld = vld_w[i-1];
		end

		if (i == riqr_pkg::MAX_ITEMS - 1) begin : g_tail
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_body
			assign r_val = val_w[i+1];
			assign r_vld = vld_w[i+1];
		end

		riqr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_len   (new_len),
			.left_gt   (l_gt),
			.left_val  (l_val),
			.left_vld  (l_vld),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (val_w[i]),
			.vld       (vld_w[i]),
			.gt        (gt_w[i])
		);
	end

endmodule

// ===== src/relative_iqr_tolerance_check_core.sv =====
// relative_iqr_tolerance_check_core: top level of the relative iqr check
// sequencer, quartile capture, multiply and compare around riqr_chain
// depends on riqr_pkg and riqr_chain
//
// Usage. Lengths arrive one word per cycle on in_data (valid/stall) while
// in_stall is low; the word with last set ends the set. Each length that
// fits is dropped into place in a chain of 1024 cells in the cycle it is
// accepted. After the last word the block stalls its input while it shifts
// the chain toward the head and picks off q1, median and q3, stopping at the
// position of q3 in the chain. The spread is then formed, the median is
// multiplied by the tolerance, and the result word is loaded into the output
// register. A set that ends after overflowing the chain skips the readout
// and the multiply, and its result goes straight to the output register.
// The result word waits in the output register while out_stall is high; input
// is taken again meanwhile, and only a second finished set waits for it.
// cfg_data writes the 8.8 tolerance; cfg_ready is always high and writes
// belong in idle time. Reset empties the chain, zeroes the count, drops any
// pending result and sets the tolerance to 0.25.
module relative_iqr_tolerance_check_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  riqr_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output riqr_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [riqr_pkg::TOL_W-1:0] cfg_data
);

	riqr_pkg::state_t state_q, state_nxt;
	riqr_pkg::chain_ctl_t ctl;

	logic [riqr_pkg::TOL_W-1:0]  tol_q;
	logic [riqr_pkg::CNT_W-1:0]  cnt_q;
	logic                        ovf_q;
	logic                        res_ovf_q;
	logic [riqr_pkg::IDX_W-1:0]  scan_q;
	logic [riqr_pkg::IDX_W-1:0]  q1_idx_q, md_idx_q, q3_idx_q;
	logic [riqr_pkg::LEN_W-1:0]  q1_q, md_q, q3_q;
	logic [riqr_pkg::LEN_W-1:0]  diff_s2;
	logic [riqr_pkg::PROD_W-1:0] prod_s2;
	logic                        out_valid_q;
	riqr_pkg::out_word_t         out_q;

	logic                        accept;
	logic                        room;
	logic                        set_ovf;
	logic                        load_out;
	logic [riqr_pkg::LEN_W-1:0]  head_val;
	logic [riqr_pkg::CNT_W-1:0]  n_set;
	logic [riqr_pkg::CNT_W+1:0]  three_n;
	logic [riqr_pkg::PROD_W-1:0] lhs;
	logic                        in_tol;

	// handshake outputs
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != riqr_pkg::ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign accept   = in_valid && !in_stall;
	assign room     = (cnt_q < riqr_pkg::CNT_W'(riqr_pkg::MAX_ITEMS));
	assign set_ovf  = ovf_q || !room;
	assign load_out = !out_valid_q || !out_stall;

	// quartile positions of the set that ends now
	assign n_set   = cnt_q + riqr_pkg::CNT_W'(1);
	assign three_n = {2'b00, n_set} + {1'b0, n_set, 1'b0};

	// exact compare in place of the division
	assign lhs    = riqr_pkg::PROD_W'({diff_s2, {riqr_pkg::FRAC_W{1'b0}}});
	assign in_tol = !res_ovf_q && (lhs <= prod_s2);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= riqr_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and chain control
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			riqr_pkg::ST_LOAD: begin
				ctl.ins = accept && room;
				if (accept && in_data.last) begin
					if (set_ovf) begin
						ctl.clr   = 1'b1;
						state_nxt = riqr_pkg::ST_FIN;
					end else begin
						state_nxt = riqr_pkg::ST_SCAN;
					end
				end
			end
			riqr_pkg::ST_SCAN: begin
				ctl.shift = 1'b1;
				if (scan_q == q3_idx_q) begin
					ctl.clr   = 1'b1;
					state_nxt = riqr_pkg::ST_MUL;
				end
			end
			riqr_pkg::ST_MUL: begin
				state_nxt = riqr_pkg::ST_FIN;
			end
			riqr_pkg::ST_FIN: begin
				if (load_out) begin
					state_nxt = riqr_pkg::ST_LOAD;
				end
			end
			default: begin
				state_nxt = riqr_pkg::ST_LOAD;
			end
		endcase
	end

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= riqr_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// set count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				cnt_q <= cnt_q + riqr_pkg::CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// quartile positions and readout index
	always_ff @(posedge clk) begin
		if (accept && in_data.last) begin
			q1_idx_q  <= riqr_pkg::IDX_W'(n_set >> 2);
			md_idx_q  <= riqr_pkg::IDX_W'(n_set >> 1);
			q3_idx_q  <= riqr_pkg::IDX_W'(three_n >> 2);
			scan_q    <= '0;
			res_ovf_q <= set_ovf;
		end else if (state_q == riqr_pkg::ST_SCAN) begin
			scan_q <= scan_q + riqr_pkg::IDX_W'(1);
		end
	end

	// pick the quartiles off the chain head
	always_ff @(posedge clk) begin
		if (state_q == riqr_pkg::ST_SCAN) begin
			if (scan_q == q1_idx_q) begin
				q1_q <= head_val;
			end
			if (scan_q == md_idx_q) begin
				md_q <= head_val;
			end
			if (scan_q == q3_idx_q) begin
				q3_q <= head_val;
			end
		end else if (accept && in_data.last && set_ovf) begin
			q1_q <= '0;
			md_q <= '0;
			q3_q <= '0;
		end
	end

	// spread and scaled median
	always_ff @(posedge clk) begin
		if (state_q == riqr_pkg::ST_MUL) begin
			diff_s2 <= q3_q - q1_q;
			prod_s2 <= riqr_pkg::PROD_W'(tol_q) * riqr_pkg::PROD_W'(md_q);
		end else if (accept && in_data.last && set_ovf) begin
			diff_s2 <= '0;
			prod_s2 <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == riqr_pkg::ST_FIN && load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == riqr_pkg::ST_FIN && load_out) begin
			out_q.within_res     <= in_tol;
			out_q.lower_quartile <= q1_q;
			out_q.middle_value   <= md_q;
			out_q.upper_quartile <= q3_q;
			out_q.overflow       <= res_ovf_q;
		end
	end

	// sorting chain
	riqr_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.new_len  (in_data.length),
		.head_val (head_val)
	);

endmodule
